@@ hw/rtl/rmpps_pkg.sv @@
// ----------------------------------------------------------------------------
// rmpps_pkg
// Shared constants and types for the rectangle minimum-price point store.
// ----------------------------------------------------------------------------
package rmpps_pkg;

  localparam int unsigned CAPACITY_DEF   = 256;
  localparam int unsigned COORD_BITS_DEF = 30;
  localparam int unsigned PRICE_W        = 31;
  localparam int unsigned OP_W           = 2;
  localparam int unsigned STATUS_W       = 2;
  localparam int unsigned INDEX_OUT_W    = 8;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_ACCEPTED = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_DROPPED  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FOUND    = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_NONE     = 2'd3;

  typedef enum logic [1:0] {
    KIND_PASS   = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_QUERY  = 2'd2
  } kind_e;

  typedef struct packed {
    logic                valid;
    kind_e               kind;
    logic [STATUS_W-1:0] status;
    logic                found;
  } tok_ctrl_t;

  localparam tok_ctrl_t TOK_CTRL_IDLE = '{
    valid:  1'b0,
    kind:   KIND_PASS,
    status: STATUS_ACCEPTED,
    found:  1'b0
  };

endpackage

@@ hw/rtl/rmpps_if.sv @@
// ----------------------------------------------------------------------------
// rmpps_if
// Valid/ready channels of the point store: operation in, result out.
// ----------------------------------------------------------------------------
interface rmpps_op_if
  import rmpps_pkg::*;
#(
  parameter int unsigned COORD_W = COORD_BITS_DEF
);
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [COORD_W-1:0] point_x;
  logic [COORD_W-1:0] point_y;
  logic [PRICE_W-1:0] point_price;
  logic [COORD_W-1:0] query_x_low;
  logic [COORD_W-1:0] query_x_high;
  logic [COORD_W-1:0] query_y_low;
  logic [COORD_W-1:0] query_y_high;

  modport source (
    output valid, operation, point_x, point_y, point_price,
           query_x_low, query_x_high, query_y_low, query_y_high,
    input  ready
  );
  modport sink (
    input  valid, operation, point_x, point_y, point_price,
           query_x_low, query_x_high, query_y_low, query_y_high,
    output ready
  );
endinterface

interface rmpps_res_if
  import rmpps_pkg::*;
#(
  parameter int unsigned COORD_W = COORD_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [STATUS_W-1:0]    status;
  logic [PRICE_W-1:0]     best_price;
  logic [COORD_W-1:0]     best_x;
  logic [COORD_W-1:0]     best_y;
  logic [INDEX_OUT_W-1:0] best_index;

  modport source (
    output valid, status, best_price, best_x, best_y, best_index,
    input  ready
  );
  modport sink (
    input  valid, status, best_price, best_x, best_y, best_index,
    output ready
  );
endinterface

@@ hw/rtl/rmpps_head.sv @@
// ----------------------------------------------------------------------------
// rmpps_head
// Entry count and decode of an incoming operation into a chain token.
// ----------------------------------------------------------------------------
module rmpps_head
  import rmpps_pkg::*;
#(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  localparam int unsigned CNT_W     = $clog2(CAPACITY + 1),
  localparam int unsigned IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rmpps_op_if.sink              in_if,
  input  logic                  advance_i,
  output tok_ctrl_t             ctrl_o,
  output logic [COORD_BITS-1:0] lo_x_o,
  output logic [COORD_BITS-1:0] hi_x_o,
  output logic [COORD_BITS-1:0] lo_y_o,
  output logic [COORD_BITS-1:0] hi_y_o,
  output logic [PRICE_W-1:0]    pt_price_o,
  output logic [CNT_W-1:0]      ref_cnt_o,
  output logic [PRICE_W-1:0]    best_price_o,
  output logic [COORD_BITS-1:0] best_x_o,
  output logic [COORD_BITS-1:0] best_y_o,
  output logic [IDX_W-1:0]      best_idx_o
);

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic [CNT_W-1:0] count_q, count_d;
  logic             full;

  assign full        = (count_q >= CAP_CNT);
  assign in_if.ready = advance_i;

  always_comb begin
    ctrl_o       = TOK_CTRL_IDLE;
    ctrl_o.valid = in_if.valid;
    count_d      = count_q;
    case (in_if.operation)
      OP_INSERT: begin
        if (full) begin
          ctrl_o.status = STATUS_DROPPED;
        end else begin
          ctrl_o.kind = KIND_INSERT;
          count_d     = count_q + CNT_W'(1);
        end
      end
      OP_QUERY: begin
        ctrl_o.kind = KIND_QUERY;
      end
      OP_CLEAR: begin
        count_d = '0;
      end
      default: begin
        ctrl_o.kind = KIND_PASS;
      end
    endcase
  end

  // insert reuses the low bounds to carry its point
  assign lo_x_o       = (in_if.operation == OP_QUERY) ? in_if.query_x_low : in_if.point_x;
  assign lo_y_o       = (in_if.operation == OP_QUERY) ? in_if.query_y_low : in_if.point_y;
  assign hi_x_o       = in_if.query_x_high;
  assign hi_y_o       = in_if.query_y_high;
  assign pt_price_o   = in_if.point_price;
  assign ref_cnt_o    = count_q;
  assign best_price_o = '0;
  assign best_x_o     = '0;
  assign best_y_o     = '0;
  assign best_idx_o   = '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (in_if.valid && advance_i) begin
      count_q <= count_d;
    end
  end

endmodule

@@ hw/rtl/rmpps_cell.sv @@
// ----------------------------------------------------------------------------
// rmpps_cell
// One store slot: holds a point and updates each passing token.
// ----------------------------------------------------------------------------
module rmpps_cell
  import rmpps_pkg::*;
#(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned INDEX      = 0,
  localparam int unsigned CNT_W     = $clog2(CAPACITY + 1),
  localparam int unsigned IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  advance_i,
  input  tok_ctrl_t             ctrl_i,
  input  logic [COORD_BITS-1:0] lo_x_i,
  input  logic [COORD_BITS-1:0] hi_x_i,
  input  logic [COORD_BITS-1:0] lo_y_i,
  input  logic [COORD_BITS-1:0] hi_y_i,
  input  logic [PRICE_W-1:0]    pt_price_i,
  input  logic [CNT_W-1:0]      ref_cnt_i,
  input  logic [PRICE_W-1:0]    best_price_i,
  input  logic [COORD_BITS-1:0] best_x_i,
  input  logic [COORD_BITS-1:0] best_y_i,
  input  logic [IDX_W-1:0]      best_idx_i,
  output tok_ctrl_t             ctrl_o,
  output logic [COORD_BITS-1:0] lo_x_o,
  output logic [COORD_BITS-1:0] hi_x_o,
  output logic [COORD_BITS-1:0] lo_y_o,
  output logic [COORD_BITS-1:0] hi_y_o,
  output logic [PRICE_W-1:0]    pt_price_o,
  output logic [CNT_W-1:0]      ref_cnt_o,
  output logic [PRICE_W-1:0]    best_price_o,
  output logic [COORD_BITS-1:0] best_x_o,
  output logic [COORD_BITS-1:0] best_y_o,
  output logic [IDX_W-1:0]      best_idx_o
);

  localparam logic [CNT_W-1:0] SLOT     = CNT_W'(INDEX);
  localparam logic [IDX_W-1:0] SLOT_IDX = IDX_W'(INDEX);

  logic [COORD_BITS-1:0] x_q, y_q;
  logic [PRICE_W-1:0]    price_q;

  tok_ctrl_t             ctrl_q, ctrl_d;
  logic [COORD_BITS-1:0] lo_x_q, hi_x_q, lo_y_q, hi_y_q;
  logic [PRICE_W-1:0]    pt_price_q;
  logic [CNT_W-1:0]      ref_cnt_q;
  logic [PRICE_W-1:0]    best_price_q;
  logic [COORD_BITS-1:0] best_x_q, best_y_q;
  logic [IDX_W-1:0]      best_idx_q;

  logic write, inside_rect, hit;

  assign write = advance_i && ctrl_i.valid && (ctrl_i.kind == KIND_INSERT)
                 && (ref_cnt_i == SLOT);

  assign inside_rect = (x_q >= lo_x_i) && (x_q <= hi_x_i)
                       && (y_q >= lo_y_i) && (y_q <= hi_y_i);

  // strict less keeps the earlier slot on equal price
  assign hit = (ctrl_i.kind == KIND_QUERY) && (SLOT < ref_cnt_i) && inside_rect
               && (!ctrl_i.found || (price_q < best_price_i));

  always_comb begin
    ctrl_d       = ctrl_i;
    ctrl_d.found = ctrl_i.found || hit;
  end

  always_ff @(posedge clk_i) begin
    if (write) begin
      x_q     <= lo_x_i;
      y_q     <= lo_y_i;
      price_q <= pt_price_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= TOK_CTRL_IDLE;
    end else if (advance_i) begin
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      lo_x_q     <= lo_x_i;
      hi_x_q     <= hi_x_i;
      lo_y_q     <= lo_y_i;
      hi_y_q     <= hi_y_i;
      pt_price_q <= pt_price_i;
      ref_cnt_q  <= ref_cnt_i;
      if (hit) begin
        best_price_q <= price_q;
        best_x_q     <= x_q;
        best_y_q     <= y_q;
        best_idx_q   <= SLOT_IDX;
      end else begin
        best_price_q <= best_price_i;
        best_x_q     <= best_x_i;
        best_y_q     <= best_y_i;
        best_idx_q   <= best_idx_i;
      end
    end
  end

  assign ctrl_o       = ctrl_q;
  assign lo_x_o       = lo_x_q;
  assign hi_x_o       = hi_x_q;
  assign lo_y_o       = lo_y_q;
  assign hi_y_o       = hi_y_q;
  assign pt_price_o   = pt_price_q;
  assign ref_cnt_o    = ref_cnt_q;
  assign best_price_o = best_price_q;
  assign best_x_o     = best_x_q;
  assign best_y_o     = best_y_q;
  assign best_idx_o   = best_idx_q;

endmodule

@@ hw/rtl/rectangle_min_price_point_store.sv @@
// ----------------------------------------------------------------------------
// rectangle_min_price_point_store
// Point store with inclusive-rectangle minimum-price query, built as a chain
// of slot cells through which every transaction travels in order.
//
//   channel  dir  payload
//   in_if    in   operation, point_x/y/price, query_x/y_low/high
//   out_if   out  status, best_price, best_x, best_y, best_index
//
// one transaction enters per cycle while the chain is not stalled; its result leaves
// through the cell chain, one registered cell per store slot
// reset clears the entry count and the chain tokens; slot contents are not reset
// a stalled result freezes the whole chain, so input ready is low only while a result waits without output ready
// ----------------------------------------------------------------------------
module rectangle_min_price_point_store
  import rmpps_pkg::*;
#(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rmpps_op_if.sink   in_if,
  rmpps_res_if.source out_if
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  tok_ctrl_t             ctrl     [CAPACITY+1];
  logic [COORD_BITS-1:0] lo_x     [CAPACITY+1];
  logic [COORD_BITS-1:0] hi_x     [CAPACITY+1];
  logic [COORD_BITS-1:0] lo_y     [CAPACITY+1];
  logic [COORD_BITS-1:0] hi_y     [CAPACITY+1];
  logic [PRICE_W-1:0]    pt_price [CAPACITY+1];
  logic [CNT_W-1:0]      ref_cnt  [CAPACITY+1];
  logic [PRICE_W-1:0]    best_price [CAPACITY+1];
  logic [COORD_BITS-1:0] best_x   [CAPACITY+1];
  logic [COORD_BITS-1:0] best_y   [CAPACITY+1];
  logic [IDX_W-1:0]      best_idx [CAPACITY+1];

  logic                   advance;
  tok_ctrl_t              tail;
  logic                   report;
  logic [IDX_W+INDEX_OUT_W-1:0] idx_ext;

  assign tail    = ctrl[CAPACITY];
  assign advance = !tail.valid || out_if.ready;

  rmpps_head #(
    .CAPACITY   (CAPACITY),
    .COORD_BITS (COORD_BITS)
  ) u_head (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_if        (in_if),
    .advance_i    (advance),
    .ctrl_o       (ctrl[0]),
    .lo_x_o       (lo_x[0]),
    .hi_x_o       (hi_x[0]),
    .lo_y_o       (lo_y[0]),
    .hi_y_o       (hi_y[0]),
    .pt_price_o   (pt_price[0]),
    .ref_cnt_o    (ref_cnt[0]),
    .best_price_o (best_price[0]),
    .best_x_o     (best_x[0]),
    .best_y_o     (best_y[0]),
    .best_idx_o   (best_idx[0])
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    rmpps_cell #(
      .CAPACITY   (CAPACITY),
      .COORD_BITS (COORD_BITS),
      .INDEX      (i)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .advance_i    (advance),
      .ctrl_i       (ctrl[i]),
      .lo_x_i       (lo_x[i]),
      .hi_x_i       (hi_x[i]),
      .lo_y_i       (lo_y[i]),
      .hi_y_i       (hi_y[i]),
      .pt_price_i   (pt_price[i]),
      .ref_cnt_i    (ref_cnt[i]),
      .best_price_i (best_price[i]),
      .best_x_i     (best_x[i]),
      .best_y_i     (best_y[i]),
      .best_idx_i   (best_idx[i]),
      .ctrl_o       (ctrl[i+1]),
      .lo_x_o       (lo_x[i+1]),
      .hi_x_o       (hi_x[i+1]),
      .lo_y_o       (lo_y[i+1]),
      .hi_y_o       (hi_y[i+1]),
      .pt_price_o   (pt_price[i+1]),
      .ref_cnt_o    (ref_cnt[i+1]),
      .best_price_o (best_price[i+1]),
      .best_x_o     (best_x[i+1]),
      .best_y_o     (best_y[i+1]),
      .best_idx_o   (best_idx[i+1])
    );
  end

  assign report  = (tail.kind == KIND_QUERY) && tail.found;
  assign idx_ext = {{INDEX_OUT_W{1'b0}}, best_idx[CAPACITY]};

  assign out_if.valid      = tail.valid;
  assign out_if.status     = (tail.kind == KIND_QUERY)
                             ? (tail.found ? STATUS_FOUND : STATUS_NONE)
                             : tail.status;
  assign out_if.best_price = report ? best_price[CAPACITY] : '0;
  assign out_if.best_x     = report ? best_x[CAPACITY] : '0;
  assign out_if.best_y     = report ? best_y[CAPACITY] : '0;
  assign out_if.best_index = report ? idx_ext[INDEX_OUT_W-1:0] : '0;

endmodule
